/* rtl/core/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix to postfix converter
// Character codes, precedence ranks, status codes, item classes, controller
// states, the result beat type and the rank and class functions.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int DEF_STACK_DEPTH = 32;

  localparam logic [7:0] LC_A     = 8'd97;
  localparam logic [7:0] LC_Z     = 8'd122;
  localparam logic [7:0] UC_A     = 8'd65;
  localparam logic [7:0] UC_Z     = 8'd90;
  localparam logic [7:0] CH_OPEN  = 8'd40;
  localparam logic [7:0] CH_CLOSE = 8'd41;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_PCT   = 8'd37;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;

  localparam logic [3:0] RANK_NONE = 4'd0;
  localparam logic [3:0] RANK_MUL  = 4'd1;
  localparam logic [3:0] RANK_ADD  = 4'd2;
  localparam logic [3:0] RANK_CMP  = 4'd3;
  localparam logic [3:0] RANK_OPEN = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMATCHED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    CL_LETTER,
    CL_OPEN,
    CL_CLOSE,
    CL_OP,
    CL_UNKNOWN,
    CL_END
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ONE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       term;
    logic [1:0] status;
    logic       last;
  } res_t;

  function automatic logic [3:0] rank_of(input logic [7:0] c);
    logic [3:0] r;
    case (c) inside
      CH_STAR, CH_SLASH, CH_PCT: r = RANK_MUL;
      CH_PLUS, CH_MINUS:         r = RANK_ADD;
      CH_LT, CH_GT:              r = RANK_CMP;
      CH_OPEN:                   r = RANK_OPEN;
      default:                   r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic cls_t classify(input logic kind, input logic [7:0] c);
    cls_t k;
    if (kind) begin
      k = CL_END;
    end else if ((c >= LC_A && c <= LC_Z) || (c >= UC_A && c <= UC_Z)) begin
      k = CL_LETTER;
    end else if (c == CH_OPEN) begin
      k = CL_OPEN;
    end else if (c == CH_CLOSE) begin
      k = CL_CLOSE;
    end else if (rank_of(c) != RANK_NONE) begin
      k = CL_OP;
    end else begin
      k = CL_UNKNOWN;
    end
    return k;
  endfunction

endpackage

/* rtl/core/itp_ram.sv */
// ----------------------------------------------------------------------------
// itp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/itp_ctrl.sv */
// ----------------------------------------------------------------------------
// itp_ctrl: shunting-yard sequencer
// Classifies each character, pops the operator stack one entry per read and
// pushes operators; holds one result back until the item's last is known.
// ----------------------------------------------------------------------------
module itp_ctrl #(
  parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_sym,
  output logic                           wr_en,
  output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic                           rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           push_valid,
  input  logic                           push_ready,
  output itp_pkg::res_t                  push_beat
);

  import itp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  state_t        state_r, state_nxt;
  cls_t          cls_r, cls_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_v_r, pend_v_nxt;
  res_t          pend_r, pend_nxt;

  logic cnt_zero, full, can_emit, top_open, top_pops, stall;
  logic emit_req, pop, stk_wr, fin;
  res_t emit_res;

  assign cnt_zero = (cnt_r == '0);
  assign full     = (cnt_r >= DEPTH_C);
  assign can_emit = !pend_v_r || push_ready;
  assign top_open = (rd_data == CH_OPEN);
  assign top_pops = (rank_of(rd_data) <= rank_of(sym_r));
  assign stall    = emit_req && !can_emit;

  assign wr_en   = stk_wr;
  assign wr_addr = AW'(cnt_r);
  assign wr_data = sym_r;
  assign rd_addr = AW'(cnt_r - CW'(1));

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    stk_wr   = 1'b0;
    emit_req = 1'b0;
    emit_res = '0;
    pop      = 1'b0;
    fin      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ: begin
        if (cnt_zero) begin
          if (cls_r == CL_END) begin
            emit_req      = 1'b1;
            emit_res.term = 1'b1;
          end else if (cls_r == CL_CLOSE) begin
            emit_req        = 1'b1;
            emit_res.status = ST_UNMATCHED;
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      S_CHECK: begin
        case (cls_r)
          CL_END, CL_CLOSE: begin
            pop = 1'b1;
            if (!top_open) begin
              emit_req     = 1'b1;
              emit_res.sym = rd_data;
            end
          end
          CL_OP: begin
            if (top_pops) begin
              pop          = 1'b1;
              emit_req     = 1'b1;
              emit_res.sym = rd_data;
            end
          end
          default: ;
        endcase
      end
      S_ONE: begin
        case (cls_r)
          CL_LETTER: begin
            emit_req     = 1'b1;
            emit_res.sym = sym_r;
          end
          CL_UNKNOWN: begin
            emit_req        = 1'b1;
            emit_res.status = ST_UNKNOWN;
          end
          default: begin
            if (full) begin
              emit_req        = 1'b1;
              emit_res.status = ST_OVERFLOW;
            end else begin
              stk_wr = 1'b1;
            end
          end
        endcase
      end
      S_FIN: begin
        fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (classify(in_kind, in_sym))
            CL_END, CL_CLOSE, CL_OP: state_nxt = S_READ;
            default:                 state_nxt = S_ONE;
          endcase
        end
      end
      S_READ: begin
        if (!cnt_zero) begin
          state_nxt = S_CHECK;
        end else if (cls_r == CL_OP) begin
          state_nxt = S_ONE;
        end else if (!stall) begin
          state_nxt = S_FIN;
        end
      end
      S_CHECK: begin
        if (!stall) begin
          case (cls_r)
            CL_CLOSE: state_nxt = top_open ? S_FIN : S_READ;
            CL_OP:    state_nxt = top_pops ? S_READ : S_ONE;
            default:  state_nxt = S_READ;
          endcase
        end
      end
      S_ONE: begin
        if (!stall) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_v_r || push_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cls_nxt        = cls_r;
    sym_nxt        = sym_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    push_valid     = 1'b0;
    push_beat      = pend_r;
    push_beat.last = 1'b0;
    if (in_ready && in_valid) begin
      cls_nxt = classify(in_kind, in_sym);
      sym_nxt = in_sym;
    end
    if (emit_req && can_emit) begin
      push_valid = pend_v_r;
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_res;
    end
    if (pop && !stall) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (stk_wr) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (fin) begin
      push_valid     = pend_v_r;
      push_beat.last = 1'b1;
      if (push_ready) begin
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r  <= cls_nxt;
    sym_r  <= sym_nxt;
    pend_r <= pend_nxt;
  end

endmodule

/* rtl/core/itp_out.sv */
// ----------------------------------------------------------------------------
// itp_out: result output register
// Holds one result beat toward the stream receiver and refills on handshake.
// ----------------------------------------------------------------------------
module itp_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  itp_pkg::res_t push_beat,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);

  import itp_pkg::*;

  logic valid_r;
  res_t beat_r;

  assign push_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      beat_r <= push_beat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = beat_r.sym;
  assign out_tuser  = {beat_r.status, beat_r.term};
  assign out_tlast  = beat_r.last;

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard infix to postfix converter
// Input stream carries one character per beat; result stream carries the
// postfix characters, terminators and error codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per beat; in_tuser = 1 ends an expression and
//           flushes the operator stack.
//   out_* : zero or more result beats per input beat; out_tlast marks the
//           final result caused by that input beat.
//   The stack lives in a RAM with a registered read; each entry examined
//   is addressed in S_READ and compared in S_CHECK. in_tready is high
//   only between items.
//   A stalled receiver holds the output register and, once the one pending
//   result is blocked too, freezes the sequencer.
//   Reset empties the stack and drops any result not yet delivered.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol_in
  input  logic       in_tuser,   // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] symbol_out
  output logic [2:0] out_tuser,  // [0] is_terminator, [2:1] status
  output logic       out_tlast
);

  import itp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  logic          push_valid, push_ready;
  res_t          push_beat;

  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_sym    (in_tdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_beat (push_beat)
  );

  itp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  itp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_beat (push_beat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

/* rtl/core/itp_chk.sv */
// ----------------------------------------------------------------------------
// itp_chk: port-level checks of the infix to postfix converter
// Watches the result stream for reset, stall and beat-format rules.
// ----------------------------------------------------------------------------
module itp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  import itp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[2:1] != ST_OK) |-> out_tlast)
    else $error("terminator or error beat not last of its item");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[2:1] != ST_OK) |-> out_tdata == 8'd0)
    else $error("terminator or error beat carries a symbol");

  a_term_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("terminator beat carries an error status");

endmodule

bind infix_to_postfix_converter_unit itp_chk u_itp_chk (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the infix to postfix converter
// Streams characters in, tracks an operator stack of its own and checks each
// result beat, field by field, in order. A short directed table covers the
// letter ranges, the unknown and unmatched codes and all operators. Mostly
// well-formed random expressions, deep nesting that can overflow the stack,
// broken sequences and raw bytes follow, varying idles and two output hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam int RANDOM_ITEMS = 445;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] OP_SET [7] = '{CH_STAR, CH_SLASH, CH_PCT, CH_PLUS,
                                        CH_MINUS, CH_LT, CH_GT};

  typedef struct {
    logic       kind;
    logic [7:0] sym;
    logic       pinned;
    res_t       want;
  } step_row_t;

  typedef struct {
    logic       kind;
    logic [7:0] sym;
  } char_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  logic [7:0] op_stack [DEPTH];
  int unsigned op_depth = 0;
  res_t batch [$];
  res_t postfix_due [$];
  char_beat_t plan [$];
  step_row_t dir_rows [$];

  int faults = 0;
  int beats_in = 0;
  int rand_sent = 0;
  int src_idle_pct = 26;
  int snk_idle_pct = 47;
  int hold_left = 0;
  int hold_idx = 0;
  int hold_mark [2] = '{80, 360};

  infix_to_postfix_converter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [3:0] prec_rank(input logic [7:0] c);
    if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) return RANK_MUL;
    if (c == CH_PLUS || c == CH_MINUS) return RANK_ADD;
    if (c == CH_LT || c == CH_GT) return RANK_CMP;
    if (c == CH_OPEN) return RANK_OPEN;
    return RANK_NONE;
  endfunction

  function automatic void emit(input logic [7:0] s, input logic t, input logic [1:0] st);
    res_t r;
    r.sym = s;
    r.term = t;
    r.status = st;
    r.last = 1'b0;
    batch.push_back(r);
  endfunction

  function automatic void shunt_char(input logic kind, input logic [7:0] c);
    logic [7:0] t;
    logic [3:0] r;
    logic       hit;
    batch.delete();
    if (kind) begin
      while (op_depth > 0) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t != CH_OPEN) emit(t, 1'b0, ST_OK);
      end
      emit(8'h00, 1'b1, ST_OK);
    end else if ((c >= LC_A && c <= LC_Z) || (c >= UC_A && c <= UC_Z)) begin
      emit(c, 1'b0, ST_OK);
    end else if (c == CH_OPEN) begin
      if (op_depth >= DEPTH) begin
        emit(8'h00, 1'b0, ST_OVERFLOW);
      end else begin
        op_stack[op_depth] = c;
        op_depth++;
      end
    end else if (c == CH_CLOSE) begin
      hit = 1'b0;
      while (op_depth > 0 && !hit) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == CH_OPEN) hit = 1'b1;
        else emit(t, 1'b0, ST_OK);
      end
      if (!hit) emit(8'h00, 1'b0, ST_UNMATCHED);
    end else begin
      r = prec_rank(c);
      if (r == RANK_NONE) begin
        emit(8'h00, 1'b0, ST_UNKNOWN);
      end else begin
        while (op_depth > 0 && prec_rank(op_stack[op_depth - 1]) <= r) begin
          emit(op_stack[op_depth - 1], 1'b0, ST_OK);
          op_depth--;
        end
        if (op_depth >= DEPTH) begin
          emit(8'h00, 1'b0, ST_OVERFLOW);
        end else begin
          op_stack[op_depth] = c;
          op_depth++;
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? LC_A : UC_A;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    return OP_SET[$urandom_range(0, 6)];
  endfunction

  function automatic void plan_char(input logic kind, input logic [7:0] sym);
    char_beat_t b;
    b.kind = kind;
    b.sym = sym;
    plan.push_back(b);
  endfunction

  function automatic void plan_expr(input int max_open, input int n_operands);
    int open_now;
    open_now = 0;
    for (int k = 0; k < n_operands; k++) begin
      while (open_now < max_open && $urandom_range(0, 99) < 30) begin
        plan_char(1'b0, CH_OPEN);
        open_now++;
      end
      plan_char(1'b0, rand_letter());
      while (open_now > 0 && $urandom_range(0, 99) < 35) begin
        plan_char(1'b0, CH_CLOSE);
        open_now--;
      end
      if (k != n_operands - 1) plan_char(1'b0, rand_op());
    end
    if ($urandom_range(0, 99) < 80) begin
      repeat (open_now) plan_char(1'b0, CH_CLOSE);
    end
    plan_char(1'b1, 8'($urandom));
  endfunction

  function automatic void plan_deep();
    int n;
    n = $urandom_range(12, 40);
    repeat (n) begin
      plan_char(1'b0, CH_OPEN);
      if ($urandom_range(0, 1)) begin
        plan_char(1'b0, rand_letter());
        plan_char(1'b0, rand_op());
      end
    end
    plan_char(1'b0, rand_letter());
    repeat ($urandom_range(0, 6)) plan_char(1'b0, CH_CLOSE);
    plan_char(1'b1, 8'($urandom));
  endfunction

  function automatic void plan_broken();
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(0, 3))
        0: plan_char(1'b0, rand_letter());
        1: plan_char(1'b0, rand_op());
        2: plan_char(1'b0, CH_OPEN);
        default: plan_char(1'b0, CH_CLOSE);
      endcase
    end
    if ($urandom_range(0, 99) < 70) plan_char(1'b1, 8'($urandom));
  endfunction

  function automatic void plan_noise();
    repeat ($urandom_range(1, 8)) plan_char($urandom_range(0, 9) == 0, 8'($urandom));
  endfunction

  task automatic offer(input logic kind, input logic [7:0] sym, input logic pinned,
                       input res_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= sym;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shunt_char(kind, sym);
    if (pinned) postfix_due.push_back(want);
    else foreach (batch[i]) postfix_due.push_back(batch[i]);
    beats_in++;
  endtask

  // hold off the output for a long stretch at each mark
  always @(negedge clk) begin
    if (hold_left == 0 && hold_idx < 2 && beats_in >= hold_mark[hold_idx]) begin
      hold_left = HOLD_CYCLES;
      hold_idx++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.sym = out_tdata;
      got.term = out_tuser[0];
      got.status = out_tuser[2:1];
      got.last = out_tlast;
      if (postfix_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected beat: sym=%h term=%b status=%0d last=%b",
                   got.sym, got.term, got.status, got.last);
      end else begin
        want = postfix_due.pop_front();
        if (got.sym !== want.sym || got.term !== want.term ||
            got.status !== want.status || got.last !== want.last) begin
          faults++;
          if (faults <= 10)
            $display("mismatch: sym %h/%h term %b/%b status %0d/%0d last %b/%b (exp/act)",
                     want.sym, got.sym, want.term, got.term,
                     want.status, got.status, want.last, got.last);
        end
      end
    end
  end

  initial begin
    dir_rows = '{
      '{1'b1, 8'hA5, 1'b1, '{8'h00, 1'b1, ST_OK, 1'b1}},
      '{1'b0, UC_A, 1'b1, '{UC_A, 1'b0, ST_OK, 1'b1}},
      '{1'b0, LC_Z, 1'b1, '{LC_Z, 1'b0, ST_OK, 1'b1}},
      '{1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, ST_UNKNOWN, 1'b1}},
      '{1'b0, 8'hFF, 1'b1, '{8'h00, 1'b0, ST_UNKNOWN, 1'b1}},
      '{1'b0, UC_A - 8'd1, 1'b1, '{8'h00, 1'b0, ST_UNKNOWN, 1'b1}},
      '{1'b0, LC_Z + 8'd1, 1'b1, '{8'h00, 1'b0, ST_UNKNOWN, 1'b1}},
      '{1'b0, CH_CLOSE, 1'b1, '{8'h00, 1'b0, ST_UNMATCHED, 1'b1}},
      '{1'b0, CH_OPEN, 1'b0, '0},
      '{1'b0, LC_A, 1'b0, '0},
      '{1'b0, CH_LT, 1'b0, '0},
      '{1'b0, LC_A + 8'd1, 1'b0, '0},
      '{1'b0, CH_CLOSE, 1'b0, '0},
      '{1'b0, CH_STAR, 1'b0, '0},
      '{1'b0, LC_A + 8'd2, 1'b0, '0},
      '{1'b0, CH_PCT, 1'b0, '0},
      '{1'b0, LC_A + 8'd3, 1'b0, '0},
      '{1'b0, CH_MINUS, 1'b0, '0},
      '{1'b0, LC_A + 8'd4, 1'b0, '0},
      '{1'b0, CH_SLASH, 1'b0, '0},
      '{1'b0, LC_A + 8'd5, 1'b0, '0},
      '{1'b0, CH_GT, 1'b0, '0},
      '{1'b0, LC_A + 8'd6, 1'b0, '0},
      '{1'b0, CH_PLUS, 1'b0, '0},
      '{1'b0, LC_A + 8'd7, 1'b0, '0},
      '{1'b0, CH_CLOSE, 1'b0, '0},
      '{1'b0, CH_OPEN, 1'b0, '0},
      '{1'b1, 8'h5A, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].kind, dir_rows[i].sym, dir_rows[i].pinned,
                                dir_rows[i].want);

    while (rand_sent < RANDOM_ITEMS) begin
      plan.delete();
      case ($urandom_range(0, 99)) inside
        [0:63]:  plan_expr($urandom_range(0, 4), $urandom_range(1, 8));
        [64:69]: plan_deep();
        [70:84]: plan_broken();
        default: plan_noise();
      endcase
      foreach (plan[i]) begin
        if (rand_sent < 150) begin
          src_idle_pct = 26;
          snk_idle_pct = 47;
        end else if (rand_sent < 300) begin
          src_idle_pct = 47;
          snk_idle_pct = 26;
        end else begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        offer(plan[i].kind, plan[i].sym, 1'b0, '0);
        rand_sent++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (postfix_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (faults == 0 && postfix_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
